@@ src/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// Interval set tracker package
// Shared types, constants and request codes for the even-odd interval tracker.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int MAX_RANGES = 16;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] span_start;
        logic signed [31:0] span_end;
    } ist_req_t;

    typedef struct packed {
        logic       is_covered;
        logic       overflowed;
        logic [4:0] range_count;
    } ist_rsp_t;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } ist_pair_t;

    typedef struct packed {
        logic               s_gt_hi;
        logic               e_lt_lo;
        logic               s_ge_e;
        logic               s_lt_lo;
        logic               e_le_hi;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } ist_fetch_t;

    typedef struct packed {
        logic               b_eq_c;
        logic               emit;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } ist_step_t;

endpackage

@@ src/ist_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module ist_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/ist_merge_unit.sv @@
// ----------------------------------------------------------------------------
// Interval merge unit
// Shared compare and select logic used for every stored interval in turn.
// ----------------------------------------------------------------------------
module ist_merge_unit (
    input  logic signed [31:0] s,
    input  logic signed [31:0] e,
    input  ist_pkg::ist_pair_t pair,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] c,
    output ist_pkg::ist_fetch_t fetch,
    output ist_pkg::ist_step_t  step
);
    import ist_pkg::*;

    logic s_lt_lo;
    logic e_lt_hi;
    logic b_gt_c;

    always_comb
    begin
        s_lt_lo       = s < pair.lo;
        e_lt_hi       = e < pair.hi;
        fetch.s_gt_hi = s > pair.hi;
        fetch.e_lt_lo = e < pair.lo;
        fetch.s_ge_e  = !(s < e);
        fetch.s_lt_lo = s_lt_lo;
        fetch.e_le_hi = !(pair.hi < e);
        fetch.a       = s_lt_lo ? s : pair.lo;
        fetch.b       = s_lt_lo ? pair.lo : s;
        fetch.c       = e_lt_hi ? e : pair.hi;
        fetch.d       = e_lt_hi ? pair.hi : e;
    end

    always_comb
    begin
        b_gt_c      = b > c;
        step.b_eq_c = (b == c);
        step.lo     = b_gt_c ? c : b;
        step.hi     = b_gt_c ? b : c;
        step.emit   = b_gt_c ? (a != c) : (a != b);
    end

endmodule

@@ src/interval_set_xor_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Even-odd interval tracker
// Keeps a sorted list of disjoint half-open intervals and combines recorded
// spans with it by symmetric difference; answers coverage queries.
//
//   Channel   Handshake             Payload
//   request   req_valid/req_stall   req_data  (func, span_start, span_end)
//   response  rsp_valid/rsp_stall   rsp_data  (is_covered, overflowed, range_count)
//
// A query passes the query and output states to the response register, a record of
// an empty span only the output state, and any other record the fetch and step states
// per stored interval (the shared merge unit visits one interval per fetch/step pair),
// then finish and output. The list lives in two RAM banks; a record reads one.
// After reset the list is empty; RAM contents need no clearing pass.
// A stalled response holds; one further request is worked on meanwhile.
// ----------------------------------------------------------------------------
module interval_set_xor_tracker_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ist_pkg::ist_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ist_pkg::ist_rsp_t rsp_data
);
    import ist_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_FETCH,
        S_STEP,
        S_FINISH,
        S_OUTPUT
    } state_t;

    typedef enum logic [1:0] {
        M_SKIP,
        M_MERGE,
        M_COPY
    } mode_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic               bank_reg, bank_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   from_reg, from_next;
    logic [CNT_W-1:0]   to_reg, to_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] e_reg, e_next;
    ist_pair_t          pair_reg, pair_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] b_reg, b_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] d_reg, d_next;
    logic               e_lt_lo_reg, e_lt_lo_next;
    logic               cov_reg, cov_next;
    logic               ovf_reg, ovf_next;
    logic               rsp_valid_reg, rsp_valid_next;
    ist_rsp_t           rsp_data_reg, rsp_data_next;

    logic               wr_en;
    ist_pair_t          wr_pair;
    logic [CNT_W-1:0]   from_inc;
    logic               append;
    logic [63:0]        rd_raw0;
    logic [63:0]        rd_raw1;
    ist_pair_t          rd_pair;
    ist_fetch_t         fetch;
    ist_step_t          step;

    ist_ram #(
        .WIDTH ($bits(ist_pair_t)),
        .DEPTH (MAX_RANGES)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en & bank_reg),
        .wr_addr (to_reg[IDX_W-1:0]),
        .wr_data (wr_pair),
        .rd_addr (from_next[IDX_W-1:0]),
        .rd_data (rd_raw0)
    );

    ist_ram #(
        .WIDTH ($bits(ist_pair_t)),
        .DEPTH (MAX_RANGES)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en & !bank_reg),
        .wr_addr (to_reg[IDX_W-1:0]),
        .wr_data (wr_pair),
        .rd_addr (from_next[IDX_W-1:0]),
        .rd_data (rd_raw1)
    );

    assign rd_pair = bank_reg ? rd_raw1 : rd_raw0;

    ist_merge_unit u_merge (
        .s     (s_reg),
        .e     (e_reg),
        .pair  (rd_pair),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .fetch (fetch),
        .step  (step)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign from_inc  = from_reg + CNT_W'(1);
    assign append    = !fetch.s_ge_e;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        bank_next      = bank_reg;
        count_next     = count_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        pair_next      = pair_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_lt_lo_next   = e_lt_lo_reg;
        cov_next       = cov_reg;
        ovf_next       = ovf_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        wr_en          = 1'b0;
        wr_pair        = pair_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                from_next = '0;
                to_next   = '0;
                if (req_valid)
                begin
                    s_next    = req_data.span_start;
                    e_next    = req_data.span_end;
                    mode_next = M_SKIP;
                    cov_next  = 1'b0;
                    ovf_next  = 1'b0;
                    if (req_data.func == FUNC_QUERY)
                    begin
                        state_next = S_QUERY;
                    end
                    else if (!(req_data.span_start < req_data.span_end))
                    begin
                        state_next = S_OUTPUT;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            S_QUERY:
            begin
                cov_next   = (count_reg == CNT_W'(1)) && !fetch.s_lt_lo && fetch.e_le_hi;
                state_next = S_OUTPUT;
            end

            S_FETCH:
            begin
                pair_next    = rd_pair;
                a_next       = fetch.a;
                b_next       = fetch.b;
                c_next       = fetch.c;
                d_next       = fetch.d;
                e_lt_lo_next = fetch.e_lt_lo;
                case (mode_reg)
                    M_SKIP:
                    begin
                        if (!fetch.s_gt_hi)
                        begin
                            mode_next = M_MERGE;
                        end
                    end
                    M_MERGE:
                    begin
                        if (fetch.s_ge_e)
                        begin
                            mode_next = M_COPY;
                        end
                    end
                    default:
                    begin
                        mode_next = M_COPY;
                    end
                endcase
                state_next = S_STEP;
            end

            S_STEP:
            begin
                if (mode_reg == M_MERGE)
                begin
                    if (e_lt_lo_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_pair.lo = s_reg;
                        wr_pair.hi = e_reg;
                        to_next    = to_reg + CNT_W'(1);
                        s_next     = pair_reg.lo;
                        e_next     = pair_reg.hi;
                    end
                    else if (step.b_eq_c)
                    begin
                        s_next = a_reg;
                        e_next = d_reg;
                    end
                    else
                    begin
                        if (step.emit)
                        begin
                            wr_en      = 1'b1;
                            wr_pair.lo = a_reg;
                            wr_pair.hi = step.lo;
                            to_next    = to_reg + CNT_W'(1);
                        end
                        s_next = step.hi;
                        e_next = d_reg;
                    end
                end
                else
                begin
                    wr_en   = 1'b1;
                    to_next = to_reg + CNT_W'(1);
                end
                from_next = from_inc;
                if (from_inc < count_reg)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (append && (to_reg == CNT_W'(MAX_RANGES)))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (append)
                    begin
                        wr_en      = 1'b1;
                        wr_pair.lo = s_reg;
                        wr_pair.hi = e_reg;
                    end
                    count_next = to_reg + CNT_W'(append);
                    bank_next  = !bank_reg;
                end
                state_next = S_OUTPUT;
            end

            S_OUTPUT:
            begin
                from_next = '0;
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.is_covered  = cov_reg;
                    rsp_data_next.overflowed  = ovf_reg;
                    rsp_data_next.range_count = 5'(count_reg);
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_SKIP;
            bank_reg      <= 1'b0;
            count_reg     <= '0;
            from_reg      <= '0;
            to_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            from_reg      <= from_next;
            to_reg        <= to_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        e_reg        <= e_next;
        pair_reg     <= pair_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        e_lt_lo_reg  <= e_lt_lo_next;
        cov_reg      <= cov_next;
        ovf_reg      <= ovf_next;
        rsp_data_reg <= rsp_data_next;
    end

endmodule

@@ src/ist_checker.sv @@
// ----------------------------------------------------------------------------
// Interval tracker checker
// Port-level properties of the interval tracker, attached by bind.
// ----------------------------------------------------------------------------
module ist_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input ist_pkg::ist_req_t req_data,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input ist_pkg::ist_rsp_t rsp_data
);
    import ist_pkg::*;

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a previous request is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
    else $error("stalled response dropped");

    // An overflow can only happen when the list is full, and it leaves it so.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.overflowed) |->
            ((rsp_data.range_count == 5'(MAX_RANGES)) && !rsp_data.is_covered))
    else $error("overflow reported with a list that is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.is_covered) |-> (rsp_data.range_count == 5'd1))
    else $error("coverage reported for a list that is not one interval");

endmodule

bind interval_set_xor_tracker_core ist_checker u_ist_checker (.*);

@@ verif/interval_tracker_checker.sv @@
// ----------------------------------------------------------------------------
// Interval tracker response checker
// Watches both channels of the even-odd interval tracker. Every accepted
// request is run through a local copy of the interval list to predict its
// response, and every accepted response is compared field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module interval_tracker_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  ist_pkg::ist_req_t req_data,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  ist_pkg::ist_rsp_t rsp_data,
    output int                mismatch_count,
    output int                outstanding
);
    import ist_pkg::*;

    localparam int SLOTS = 2 * MAX_RANGES;

    logic signed [31:0] bounds [0:SLOTS-1];
    int                 held_count;
    ist_rsp_t           expected_rsp_q [$];

    function automatic bit merge_span(input logic signed [31:0] s_in,
                                      input logic signed [31:0] e_in);
        logic signed [31:0] work [0:SLOTS+3];
        logic signed [31:0] s;
        logic signed [31:0] e;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] t;
        int lim;
        int src;
        int dst;
        int i;
        s = s_in;
        e = e_in;
        if (s >= e)
        begin
            return 1'b0;
        end
        for (i = 0; i < SLOTS + 4; i++)
        begin
            work[i] = (i < SLOTS) ? bounds[i] : '0;
        end
        lim = 2 * held_count;
        src = 0;
        while (src < lim && s > work[src + 1])
        begin
            src += 2;
        end
        dst = src;
        while (src < lim)
        begin
            lo = work[src];
            hi = work[src + 1];
            src += 2;
            if (e < lo)
            begin
                work[dst]     = s;
                work[dst + 1] = e;
                dst += 2;
                s = lo;
                e = hi;
            end
            else
            begin
                if (s < lo)
                begin
                    a = s;
                    b = lo;
                end
                else
                begin
                    a = lo;
                    b = s;
                end
                if (e < hi)
                begin
                    c = e;
                    d = hi;
                end
                else
                begin
                    c = hi;
                    d = e;
                end
                if (b == c)
                begin
                    s = a;
                    e = d;
                end
                else
                begin
                    if (b > c)
                    begin
                        t = c;
                        c = b;
                        b = t;
                    end
                    if (a != b)
                    begin
                        work[dst]     = a;
                        work[dst + 1] = b;
                        dst += 2;
                    end
                    s = c;
                    e = d;
                end
                if (s >= e)
                begin
                    break;
                end
            end
        end
        if (dst < src && src < lim)
        begin
            for (i = 0; i < lim - src; i++)
            begin
                work[dst + i] = work[src + i];
            end
        end
        dst += lim - src;
        if (s < e)
        begin
            work[dst]     = s;
            work[dst + 1] = e;
            dst += 2;
        end
        if (dst > SLOTS)
        begin
            return 1'b1;
        end
        for (i = 0; i < dst; i++)
        begin
            bounds[i] = work[i];
        end
        held_count = dst / 2;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        ist_rsp_t want;
        int i;
        int errs;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                bounds[i] = '0;
            end
            held_count = 0;
            expected_rsp_q.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            errs = 0;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("no request waiting: is_covered %0d, overflowed %0d, range_count %0d",
                           rsp_data.is_covered, rsp_data.overflowed,
                           rsp_data.range_count);
                    errs++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_data.is_covered !== want.is_covered)
                    begin
                        $error("is_covered: expected %0d, actual %0d",
                               want.is_covered, rsp_data.is_covered);
                        errs++;
                    end
                    if (rsp_data.overflowed !== want.overflowed)
                    begin
                        $error("overflowed: expected %0d, actual %0d",
                               want.overflowed, rsp_data.overflowed);
                        errs++;
                    end
                    if (rsp_data.range_count !== want.range_count)
                    begin
                        $error("range_count: expected %0d, actual %0d",
                               want.range_count, rsp_data.range_count);
                        errs++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                want = '0;
                if (req_data.func == FUNC_RECORD)
                begin
                    want.overflowed = merge_span(req_data.span_start, req_data.span_end);
                end
                else
                begin
                    want.is_covered = (held_count == 1) &&
                                      (bounds[0] <= req_data.span_start) &&
                                      (bounds[1] >= req_data.span_end);
                end
                want.range_count = 5'(held_count);
                expected_rsp_q.push_back(want);
            end
            mismatch_count <= mismatch_count + errs;
            outstanding    <= expected_rsp_q.size();
        end
    end

endmodule

@@ verif/tb_interval_set_xor_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Interval tracker testbench
// Drives the even-odd interval tracker with a directed opening and then
// random episodes that build an interval list, query it and take it apart
// again, including runs that fill the list to capacity and push past it.
// Both channels idle and stall at random; a separate checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module tb_interval_set_xor_tracker_core;

    import ist_pkg::*;

    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] UNIT      = 32'sh0001_0000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 2 * MAX_RANGES + 16;
    localparam int LIMIT_CYCLES = 600000;

    typedef enum int {EP_BUILD, EP_CHAIN, EP_OVERFLOW, EP_NOISE} episode_kind_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    ist_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ist_rsp_t rsp_data;

    int mismatch_count;
    int outstanding;
    int requests_sent   = 0;
    int responses_taken = 0;

    logic signed [31:0] span_lo [0:MAX_RANGES-1];
    logic signed [31:0] span_hi [0:MAX_RANGES-1];
    int                 span_n;
    int                 order [0:MAX_RANGES-1];

    interval_set_xor_tracker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    interval_tracker_checker i_span_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("interval_set_xor_tracker_core verification failed");
        $finish;
    end

    task automatic send_request(input logic f, input logic signed [31:0] s,
                                input logic signed [31:0] e);
        int gap;
        gap = (((requests_sent / 90) % 4) == 1) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_data.func       <= f;
        req_data.span_start <= s;
        req_data.span_end   <= e;
        req_valid           <= 1'b1;
        do @(posedge clk); while (!(req_valid && !req_stall));
        requests_sent++;
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic signed [31:0] grid_coord();
        int k;
        logic signed [31:0] v;
        k = $urandom_range(0, 40);
        v = (k - 20) * UNIT;
        if ($urandom_range(0, 3) == 0)
        begin
            v = v + $urandom_range(1, 16'hFFFF);
        end
        return v;
    endfunction

    task automatic issue_query();
        int j;
        logic signed [31:0] s;
        logic signed [31:0] e;
        j = $urandom_range(0, span_n - 1);
        case ($urandom_range(0, 6))
            0:
            begin
                s = span_lo[j];
                e = span_hi[j];
            end
            1:
            begin
                s = span_lo[0];
                e = span_hi[span_n - 1];
            end
            2:
            begin
                s = span_lo[j];
                e = span_lo[j];
            end
            3:
            begin
                s = grid_coord();
                e = grid_coord();
            end
            4:
            begin
                s = $urandom();
                e = $urandom();
            end
            5:
            begin
                s = COORD_MIN;
                e = COORD_MAX;
            end
            default:
            begin
                s = span_hi[j];
                e = span_lo[j];
            end
        endcase
        send_request(FUNC_QUERY, s, e);
    endtask

    task automatic record_spans(input bit chatty);
        int i;
        int j;
        int t;
        for (i = 0; i < span_n; i++)
        begin
            order[i] = i;
        end
        for (i = span_n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (i = 0; i < span_n; i++)
        begin
            send_request(FUNC_RECORD, span_lo[order[i]], span_hi[order[i]]);
            if (chatty && $urandom_range(0, 1) == 0)
            begin
                issue_query();
            end
        end
    endtask

    task automatic run_build();
        int i;
        logic signed [31:0] t;
        span_n = $urandom_range(1, MAX_RANGES);
        for (i = 0; i < span_n; i++)
        begin
            span_lo[i] = grid_coord();
            span_hi[i] = grid_coord();
            if (span_lo[i] > span_hi[i] && $urandom_range(0, 7) != 0)
            begin
                t          = span_lo[i];
                span_lo[i] = span_hi[i];
                span_hi[i] = t;
            end
        end
        record_spans(1'b1);
        record_spans(1'b1);
    endtask

    task automatic run_chain();
        int i;
        logic signed [31:0] x;
        span_n = $urandom_range(1, MAX_RANGES);
        x = grid_coord();
        for (i = 0; i < span_n; i++)
        begin
            span_lo[i] = x;
            x = x + UNIT * $urandom_range(1, 3);
            span_hi[i] = x;
        end
        record_spans(1'b1);
        repeat (3) issue_query();
        record_spans(1'b1);
    endtask

    task automatic run_overflow();
        int i;
        int j;
        logic signed [31:0] base;
        span_n = MAX_RANGES;
        base = grid_coord();
        for (i = 0; i < span_n; i++)
        begin
            span_lo[i] = base + i * 4 * UNIT;
            span_hi[i] = span_lo[i] + 2 * UNIT;
        end
        record_spans(1'b0);
        j = $urandom_range(0, span_n - 2);
        send_request(FUNC_RECORD, span_hi[span_n - 1] + 2 * UNIT,
                     span_hi[span_n - 1] + 3 * UNIT);
        send_request(FUNC_RECORD, span_lo[j] + 1, span_hi[j] - 1);
        issue_query();
        send_request(FUNC_RECORD, span_lo[0] - 3 * UNIT, span_lo[0] - UNIT);
        send_request(FUNC_RECORD, span_hi[j], span_lo[j + 1]);
        issue_query();
        send_request(FUNC_RECORD, span_hi[j], span_lo[j + 1]);
        send_request(FUNC_RECORD, span_lo[j], span_hi[j]);
        send_request(FUNC_RECORD, span_lo[j], span_hi[j]);
        send_request(FUNC_RECORD, span_lo[j + 1] - UNIT, span_hi[j + 1]);
        send_request(FUNC_RECORD, span_lo[j + 1] - UNIT, span_hi[j + 1]);
        issue_query();
        record_spans(1'b1);
    endtask

    task automatic run_noise();
        int i;
        span_n = $urandom_range(1, MAX_RANGES);
        for (i = 0; i < span_n; i++)
        begin
            span_lo[i] = ($urandom_range(0, 9) == 0) ? COORD_MIN : $urandom();
            span_hi[i] = ($urandom_range(0, 9) == 0) ? COORD_MAX : $urandom();
        end
        record_spans(1'b1);
        record_spans(1'b1);
    endtask

    initial
    begin : response_side
        int gap;
        wait (rst_n);
        forever
        begin
            gap = (((responses_taken / 70) % 4) == 3) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!(rsp_valid && !rsp_stall));
            responses_taken++;
        end
    end

    initial
    begin : stimulus
        int ep_idx;
        int random_start;
        episode_kind_t kind;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(FUNC_QUERY, 0, 0);
        send_request(FUNC_RECORD, 5 * UNIT, 5 * UNIT);
        send_request(FUNC_RECORD, COORD_MAX, COORD_MIN);
        send_request(FUNC_RECORD, COORD_MIN, COORD_MAX);
        send_request(FUNC_QUERY, COORD_MIN, COORD_MAX);
        send_request(FUNC_QUERY, COORD_MAX, COORD_MIN);
        send_request(FUNC_RECORD, UNIT, 2 * UNIT);
        send_request(FUNC_QUERY, 0, 1);
        send_request(FUNC_RECORD, 2 * UNIT, 3 * UNIT);
        send_request(FUNC_RECORD, UNIT, 3 * UNIT);
        send_request(FUNC_QUERY, COORD_MIN, COORD_MAX);
        send_request(FUNC_RECORD, COORD_MIN, COORD_MAX);
        send_request(FUNC_QUERY, 0, 0);
        send_request(FUNC_RECORD, -1, 0);
        send_request(FUNC_QUERY, -1, 0);
        send_request(FUNC_QUERY, -2, 0);
        send_request(FUNC_RECORD, 0, 1);
        send_request(FUNC_QUERY, -1, 1);
        send_request(FUNC_RECORD, -1, 1);
        wait_for_responses();

        ep_idx       = 0;
        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            if ((ep_idx % 6) == 2)
            begin
                kind = EP_OVERFLOW;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1:    kind = EP_BUILD;
                    2, 3:    kind = EP_CHAIN;
                    default: kind = EP_NOISE;
                endcase
            end
            case (kind)
                EP_BUILD:    run_build();
                EP_CHAIN:    run_chain();
                EP_OVERFLOW: run_overflow();
                default:     run_noise();
            endcase
            if ((ep_idx % 12) == 11)
            begin
                wait_for_responses();
            end
            ep_idx++;
        end

        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("interval_set_xor_tracker_core verification clean");
        end
        else
        begin
            $display("interval_set_xor_tracker_core verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ist_pkg.sv
src/ist_ram.sv
src/ist_merge_unit.sv
src/interval_set_xor_tracker_core.sv
src/ist_checker.sv
verif/interval_tracker_checker.sv
verif/tb_interval_set_xor_tracker_core.sv
